@@ rtl/clt_pkg.sv @@
// ----------------------------------------------------------------------------
// clt_pkg: shared definitions of the token lexer
// Mode and kind codes, character constants, the token word type and the
// character class functions used by the lexer core and the top level.
// ----------------------------------------------------------------------------
package clt_pkg;

    localparam int POSITION_BITS = 16;
    localparam int OFFSET_BITS   = 16;
    localparam int LENGTH_BITS   = 16;
    localparam int KIND_BITS     = 4;
    localparam int MODE_BITS     = 4;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [MODE_BITS-1:0] MODE_IDLE       = 4'd0;
    localparam logic [MODE_BITS-1:0] MODE_SLASH      = 4'd1;
    localparam logic [MODE_BITS-1:0] MODE_LINE       = 4'd2;
    localparam logic [MODE_BITS-1:0] MODE_BLOCK      = 4'd3;
    localparam logic [MODE_BITS-1:0] MODE_BLOCK_STAR = 4'd4;
    localparam logic [MODE_BITS-1:0] MODE_IDENT      = 4'd5;
    localparam logic [MODE_BITS-1:0] MODE_NUMBER     = 4'd6;
    localparam logic [MODE_BITS-1:0] MODE_STRING     = 4'd7;
    localparam logic [MODE_BITS-1:0] MODE_STRING_ESC = 4'd8;

    localparam logic [KIND_BITS-1:0] KIND_UNKNOWN   = 4'd0;
    localparam logic [KIND_BITS-1:0] KIND_IDENT     = 4'd1;
    localparam logic [KIND_BITS-1:0] KIND_LPAREN    = 4'd2;
    localparam logic [KIND_BITS-1:0] KIND_RPAREN    = 4'd3;
    localparam logic [KIND_BITS-1:0] KIND_LBRACE    = 4'd4;
    localparam logic [KIND_BITS-1:0] KIND_RBRACE    = 4'd5;
    localparam logic [KIND_BITS-1:0] KIND_LBRACKET  = 4'd6;
    localparam logic [KIND_BITS-1:0] KIND_RBRACKET  = 4'd7;
    localparam logic [KIND_BITS-1:0] KIND_EQUAL     = 4'd8;
    localparam logic [KIND_BITS-1:0] KIND_STAR      = 4'd9;
    localparam logic [KIND_BITS-1:0] KIND_COLON     = 4'd10;
    localparam logic [KIND_BITS-1:0] KIND_SEMICOLON = 4'd11;
    localparam logic [KIND_BITS-1:0] KIND_STRING    = 4'd12;
    localparam logic [KIND_BITS-1:0] KIND_NUMBER    = 4'd13;
    localparam logic [KIND_BITS-1:0] KIND_END       = 4'd14;

    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_RETURN     = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_SEMICOLON  = 8'h3B;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_LBRACKET   = 8'h5B;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CH_RBRACKET   = 8'h5D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;

    localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;

    typedef struct packed {
        logic [KIND_BITS-1:0]   kind;
        logic [OFFSET_BITS-1:0] start;
        logic [LENGTH_BITS-1:0] length;
        logic                   last;
    } token_t;

    typedef struct packed {
        logic   first_valid;
        logic   second_valid;
        token_t first;
        token_t second;
    } emit_t;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_NEWLINE || b == CH_RETURN;
    endfunction

    function automatic logic [KIND_BITS-1:0] punct_kind(input logic [7:0] b);
        logic [KIND_BITS-1:0] k;
        case (b)
            CH_LPAREN:    k = KIND_LPAREN;
            CH_RPAREN:    k = KIND_RPAREN;
            CH_LBRACE:    k = KIND_LBRACE;
            CH_RBRACE:    k = KIND_RBRACE;
            CH_LBRACKET:  k = KIND_LBRACKET;
            CH_RBRACKET:  k = KIND_RBRACKET;
            CH_EQUAL:     k = KIND_EQUAL;
            CH_STAR:      k = KIND_STAR;
            CH_COLON:     k = KIND_COLON;
            CH_SEMICOLON: k = KIND_SEMICOLON;
            default:      k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] v);
        return (v != LENGTH_MAX) ? v + LENGTH_BITS'(1) : v;
    endfunction

endpackage

@@ rtl/clt_if.sv @@
// ----------------------------------------------------------------------------
// clt_byte_if / clt_token_if: valid/ready channels of the token lexer
// The byte channel carries one text byte per word; the token channel carries
// one token per word.
// ----------------------------------------------------------------------------
interface clt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface clt_token_if;
    logic                                 valid;
    logic                                 ready;
    logic [clt_pkg::KIND_BITS-1:0]        token_kind;
    logic [clt_pkg::OFFSET_BITS-1:0]      start_offset;
    logic [clt_pkg::LENGTH_BITS-1:0]      token_length;
    logic                                 last;

    modport source (output valid, output token_kind, output start_offset,
                    output token_length, output last, input ready);
    modport sink (input valid, input token_kind, input start_offset,
                  input token_length, input last, output ready);
endinterface

@@ rtl/clt_core.sv @@
// ----------------------------------------------------------------------------
// clt_core: lexer state and step logic
// Holds the lexing mode, byte position, pending token start and length, and
// computes the zero, one or two tokens that the current byte completes.
// ----------------------------------------------------------------------------
module clt_core #(
    parameter int POSITION_BITS = clt_pkg::POSITION_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step_en,
    input  logic [7:0]     data_byte,
    output clt_pkg::emit_t emit
);

    localparam int OB = clt_pkg::OFFSET_BITS;
    localparam int LB = clt_pkg::LENGTH_BITS;

    logic [clt_pkg::MODE_BITS-1:0] mode_reg, mode_next;
    logic [POSITION_BITS-1:0]      pos_reg, pos_next;
    logic [POSITION_BITS-1:0]      begin_reg, begin_next;
    logic [LB-1:0]                 len_reg, len_next;

    logic                          use_idle;
    logic                          pre_emit;
    logic [clt_pkg::KIND_BITS-1:0] pre_kind;
    logic                          idle_emit;
    logic [clt_pkg::KIND_BITS-1:0] idle_kind;
    clt_pkg::token_t               pre_tok, idle_tok;

    always_comb
    begin
        mode_next  = mode_reg;
        begin_next = begin_reg;
        len_next   = len_reg;
        use_idle   = 1'b0;
        pre_emit   = 1'b0;
        pre_kind   = clt_pkg::KIND_UNKNOWN;
        idle_emit  = 1'b0;
        idle_kind  = clt_pkg::KIND_UNKNOWN;

        case (mode_reg)
            clt_pkg::MODE_SLASH:
            begin
                if (data_byte == clt_pkg::CH_SLASH)
                begin
                    mode_next = clt_pkg::MODE_LINE;
                end
                else if (data_byte == clt_pkg::CH_STAR)
                begin
                    mode_next = clt_pkg::MODE_BLOCK;
                end
                else
                begin
                    pre_emit = 1'b1;
                    pre_kind = clt_pkg::KIND_UNKNOWN;
                    use_idle = 1'b1;
                end
            end
            clt_pkg::MODE_LINE:
            begin
                if (data_byte == clt_pkg::CH_NUL || data_byte == clt_pkg::CH_NEWLINE ||
                    data_byte == clt_pkg::CH_RETURN)
                begin
                    use_idle = 1'b1;
                end
            end
            clt_pkg::MODE_BLOCK, clt_pkg::MODE_BLOCK_STAR:
            begin
                if (data_byte == clt_pkg::CH_NUL)
                begin
                    use_idle = 1'b1;
                end
                else if (data_byte == clt_pkg::CH_STAR)
                begin
                    mode_next = clt_pkg::MODE_BLOCK_STAR;
                end
                else if (data_byte == clt_pkg::CH_SLASH &&
                         mode_reg == clt_pkg::MODE_BLOCK_STAR)
                begin
                    mode_next = clt_pkg::MODE_IDLE;
                end
                else
                begin
                    mode_next = clt_pkg::MODE_BLOCK;
                end
            end
            clt_pkg::MODE_IDENT:
            begin
                if (clt_pkg::is_letter(data_byte) || clt_pkg::is_digit(data_byte) ||
                    data_byte == clt_pkg::CH_UNDERSCORE)
                begin
                    len_next = clt_pkg::sat_inc(len_reg);
                end
                else
                begin
                    pre_emit = 1'b1;
                    pre_kind = clt_pkg::KIND_IDENT;
                    use_idle = 1'b1;
                end
            end
            clt_pkg::MODE_NUMBER:
            begin
                if (clt_pkg::is_digit(data_byte))
                begin
                    len_next = clt_pkg::sat_inc(len_reg);
                end
                else
                begin
                    pre_emit = 1'b1;
                    pre_kind = clt_pkg::KIND_NUMBER;
                    use_idle = 1'b1;
                end
            end
            clt_pkg::MODE_STRING, clt_pkg::MODE_STRING_ESC:
            begin
                if (data_byte == clt_pkg::CH_NUL)
                begin
                    pre_emit = 1'b1;
                    pre_kind = clt_pkg::KIND_STRING;
                    use_idle = 1'b1;
                end
                else if (mode_reg == clt_pkg::MODE_STRING_ESC)
                begin
                    len_next  = clt_pkg::sat_inc(len_reg);
                    mode_next = clt_pkg::MODE_STRING;
                end
                else if (data_byte == clt_pkg::CH_QUOTE)
                begin
                    pre_emit  = 1'b1;
                    pre_kind  = clt_pkg::KIND_STRING;
                    mode_next = clt_pkg::MODE_IDLE;
                end
                else
                begin
                    len_next = clt_pkg::sat_inc(len_reg);
                    if (data_byte == clt_pkg::CH_BACKSLASH)
                    begin
                        mode_next = clt_pkg::MODE_STRING_ESC;
                    end
                end
            end
            default:
            begin
                use_idle = 1'b1;
            end
        endcase

        if (use_idle)
        begin
            mode_next = clt_pkg::MODE_IDLE;
            if (data_byte == clt_pkg::CH_NUL)
            begin
                idle_emit = 1'b1;
                idle_kind = clt_pkg::KIND_END;
            end
            else if (clt_pkg::is_space(data_byte))
            begin
                idle_emit = 1'b0;
            end
            else if (data_byte == clt_pkg::CH_SLASH)
            begin
                mode_next  = clt_pkg::MODE_SLASH;
                begin_next = pos_reg;
            end
            else if (data_byte == clt_pkg::CH_QUOTE)
            begin
                mode_next  = clt_pkg::MODE_STRING;
                begin_next = pos_reg + POSITION_BITS'(1);
                len_next   = '0;
            end
            else if (clt_pkg::is_letter(data_byte) || clt_pkg::is_digit(data_byte))
            begin
                mode_next  = clt_pkg::is_letter(data_byte) ? clt_pkg::MODE_IDENT
                                                           : clt_pkg::MODE_NUMBER;
                begin_next = pos_reg;
                len_next   = LB'(1);
            end
            else
            begin
                idle_emit = 1'b1;
                idle_kind = clt_pkg::punct_kind(data_byte);
            end
        end

        if (data_byte == clt_pkg::CH_NUL)
        begin
            mode_next = clt_pkg::MODE_IDLE;
            pos_next  = '0;
        end
        else
        begin
            pos_next = pos_reg + POSITION_BITS'(1);
        end
    end

    always_comb
    begin
        pre_tok.kind    = pre_kind;
        pre_tok.start   = OB'(begin_reg);
        pre_tok.length  = (mode_reg == clt_pkg::MODE_SLASH) ? LB'(1) : len_reg;
        pre_tok.last    = ~idle_emit;
        idle_tok.kind   = idle_kind;
        idle_tok.start  = OB'(pos_reg);
        idle_tok.length = LB'(1);
        idle_tok.last   = 1'b1;

        emit.first_valid  = pre_emit | idle_emit;
        emit.second_valid = pre_emit & idle_emit;
        emit.first        = pre_emit ? pre_tok : idle_tok;
        emit.second       = idle_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= clt_pkg::MODE_IDLE;
            pos_reg   <= '0;
            begin_reg <= '0;
            len_reg   <= '0;
        end
        else if (step_en)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            begin_reg <= begin_next;
            len_reg   <= len_next;
        end
    end

endmodule

@@ rtl/c_like_token_lexer_unit.sv @@
// ----------------------------------------------------------------------------
// c_like_token_lexer_unit: streaming lexer for a small C-like token set
// Text bytes enter on byte_in, one byte per word, and tokens leave on
// token_out, one token per word, each with its kind, start offset, length
// and a last flag that marks the final token caused by a byte.
//
// A byte is taken whenever the token queue has room for two words, so the
// block accepts one byte per cycle as long as the receiver keeps up. The
// tokens of a byte are registered in the token queue before they appear on
// token_out. A byte can complete two tokens; these leave one after the other
// through a four-word queue, so the sustained rate is one byte per cycle
// unless the token stream itself exceeds one word per cycle.
//
// When the receiver stalls, the queue fills and byte_in.ready drops once
// fewer than two places remain; no token is lost. Reset clears the queue and
// returns the lexer to the idle mode at offset zero. A zero byte ends the
// text, emits the end token and restarts offsets at zero.
// ----------------------------------------------------------------------------
module c_like_token_lexer_unit #(
    parameter int POSITION_BITS = clt_pkg::POSITION_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    clt_byte_if.sink           byte_in,
    clt_token_if.source        token_out
);

    localparam int DEPTH  = clt_pkg::QUEUE_DEPTH;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    clt_pkg::emit_t  emit;
    clt_pkg::token_t queue_reg [DEPTH];
    clt_pkg::token_t head;

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             step_en;
    logic             pop;
    logic [CNT_W-1:0] push_cnt;

    assign byte_in.ready = (count_reg <= CNT_W'(DEPTH - 2));
    assign step_en       = byte_in.valid & byte_in.ready;

    clt_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .data_byte (byte_in.data_byte),
        .emit      (emit)
    );

    assign head                   = queue_reg[rd_ptr_reg];
    assign token_out.valid        = (count_reg != '0);
    assign token_out.token_kind   = head.kind;
    assign token_out.start_offset = head.start;
    assign token_out.token_length = head.length;
    assign token_out.last         = head.last;

    assign pop = token_out.valid & token_out.ready;

    always_comb
    begin
        push_cnt = '0;
        if (step_en)
        begin
            push_cnt = CNT_W'(emit.first_valid) + CNT_W'(emit.second_valid);
        end
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + push_cnt - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (step_en && emit.first_valid)
        begin
            queue_reg[wr_ptr_reg] <= emit.first;
        end
        if (step_en && emit.second_valid)
        begin
            queue_reg[wr_ptr_reg + PTR_W'(1)] <= emit.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
